[hw/rtl/bpe_pkg.sv]
// Package: constants and types for the Bernstein polynomial evaluator.
package bpe_pkg;
   localparam int MaxDegreeDefault = 15;
   localparam int DimsDefault      = 3;
   localparam int ValueWidth       = 32;
   localparam int TauWidth         = 17;
   localparam int WeightWidth      = 31;
   localparam int TimeWidth        = 16;
   localparam int DegreeWidth      = 4;
   localparam int DimWidth         = 2;
   localparam int PointWidth       = 4;

   localparam logic [DegreeWidth-1:0] DegreeReset    = 4'd3;
   localparam logic [TimeWidth-1:0]   FinalTimeReset = 16'hFFFF;

   typedef enum logic [0:0] {
      CSR_DEGREE     = 1'b0,
      CSR_FINAL_TIME = 1'b1
   } csr_index_type;

   typedef enum logic [0:0] {
      REQ_LOAD = 1'b0,
      REQ_EVAL = 1'b1
   } req_kind_type;
endpackage

[hw/rtl/bernstein_polynomial_evaluator_core.sv]
// Top level: Bernstein polynomial evaluator core with control point memory.
//
// Use: a request beat is taken when start is high and busy is low.
// A load beat (req_type = 0) writes one Q16.16 coordinate of one control
// point into the point memory; it gives no result.
// An evaluate beat (req_type = 1) computes tau = eval_time/final_time by a
// restoring divider (17 steps, skipped when clamped), builds the Bernstein
// weights by de Casteljau levels (one multiply-add per weight per cycle,
// skipped at n = 0), then for each dimension walks the n+1 points through
// the memory read port with one 32x32 multiply a cycle, then an output state.
// Each result is strobed by rsp_valid for one cycle; DIMS results
// per evaluate, last on the final dimension. The last result is strobed in
// the cycle busy falls. One evaluate per busy span; loads go back to back.
// The receiver cannot stall the block.
// The user writes config over the csr_ channel only while idle; the block
// does not enforce this. csr_ready is always high. Synchronous reset returns
// control to idle and the registers to degree 3, final_time 65535. The point
// memory is not cleared: points must be loaded before they are used.
module bernstein_polynomial_evaluator_core
   import bpe_pkg::*;
#(
   parameter int MAX_DEGREE = MaxDegreeDefault,
   parameter int DIMS       = DimsDefault
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic                          req_type,
   input  logic [PointWidth-1:0]         req_point_index,
   input  logic [DimWidth-1:0]           req_dim_index,
   input  logic signed [ValueWidth-1:0]  req_point_value,
   input  logic [TimeWidth-1:0]          req_eval_time,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [0:0]                    csr_index,
   input  logic [TimeWidth-1:0]          csr_data,
   output logic                          rsp_valid,
   output logic [DimWidth-1:0]           rsp_out_dim,
   output logic signed [ValueWidth-1:0]  rsp_value,
   output logic                          rsp_clamped,
   output logic                          rsp_last
);
   localparam int Npts    = MAX_DEGREE + 1;
   localparam int KW      = $clog2(Npts + 1);
   localparam int DW      = (DIMS > 1) ? $clog2(DIMS) : 1;
   localparam int Depth   = Npts * DIMS;
   localparam int AW      = $clog2(Depth);
   localparam int AccW    = ValueWidth + WeightWidth + KW + 1;

   typedef enum logic [2:0] {
      ST_IDLE, ST_DIV, ST_LEVEL, ST_MAC, ST_OUT
   } state_type;

   // Config registers
   logic [DegreeWidth-1:0] degree_ff;
   logic [TimeWidth-1:0]   final_time_ff;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         degree_ff     <= DegreeReset;
         final_time_ff <= FinalTimeReset;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_DEGREE:     degree_ff     <= csr_data[DegreeWidth-1:0];
            CSR_FINAL_TIME: final_time_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // Point memory, one write and one registered read port
   logic [ValueWidth-1:0] mem [Depth];
   logic [ValueWidth-1:0] rd_data_ff;
   logic [AW-1:0]         rd_addr;
   logic                  accept;
   logic                  wr_en;
   logic [AW-1:0]         wr_addr;

   assign accept = start && !busy;
   assign wr_addr = AW'(32'(req_point_index) * DIMS + 32'(req_dim_index));
   assign wr_en = accept && (req_type == REQ_LOAD) &&
                  (32'(req_point_index) <= MAX_DEGREE) && (32'(req_dim_index) < DIMS);

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= req_point_value;
      rd_data_ff <= mem[rd_addr];
   end

   // Datapath state
   state_type               state_ff;
   logic [KW-1:0]           n_ff;
   logic [TimeWidth-1:0]    ft_ff;
   logic [TimeWidth+16:0]   rem_ff;     // dividend bits not yet shifted in
   logic [TimeWidth-1:0]    part_ff;    // partial remainder
   logic [TimeWidth:0]      quo_ff;
   logic [4:0]              div_cnt_ff;
   logic [TauWidth-1:0]     tau_ff;
   logic                    clamped_ff;
   logic [WeightWidth-1:0]  w_ff [Npts];
   logic [WeightWidth-1:0]  wprev_ff;   // w[k-1] of the previous level
   logic [KW-1:0]           lvl_ff;
   logic [KW-1:0]           k_ff;       // weight index for level / point
   logic [DW-1:0]           d_ff;
   logic [KW-1:0]           rk_ff;      // point index of data in rd_data_ff
   logic                    rvalid_ff;
   logic signed [AccW-1:0]  acc_ff;

   // effective final time and dividend t*65536 + ft/2
   logic [TimeWidth-1:0]  ft_eff;
   logic [TimeWidth+16:0] dividend;
   assign ft_eff = (final_time_ff == '0) ? TimeWidth'(1) : final_time_ff;
   assign dividend = {1'b0, req_eval_time, 16'd0} + (TimeWidth+17)'(ft_eff >> 1);

   logic [TauWidth-1:0] u_val;
   assign u_val = TauWidth'(17'h10000) - tau_ff;

   // Level update: w'[k] = (u*w[k] + tau*w[k-1] + 2^15) >> 16
   logic [WeightWidth+TauWidth:0] lvl_sum;
   logic [WeightWidth-1:0]        wk_cur, wkm1;
   always_comb begin
      wk_cur = (k_ff == lvl_ff) ? '0 : w_ff[k_ff[KW-2:0]];
      wkm1   = (k_ff == '0) ? '0 : wprev_ff;
      lvl_sum = (WeightWidth+TauWidth+1)'(u_val) * wk_cur
              + (WeightWidth+TauWidth+1)'(tau_ff) * wkm1
              + (WeightWidth+TauWidth+1)'(32768);
   end

   // Multiply-accumulate of one weight by one point
   logic signed [ValueWidth+WeightWidth:0] prod;
   assign prod = $signed(rd_data_ff) * $signed({1'b0, w_ff[rk_ff[KW-2:0]]});

   // Rounding and saturation of the sum
   logic signed [AccW-1:0] rnd;
   logic signed [AccW-31:0] shifted;
   logic signed [ValueWidth-1:0] sat_val;
   always_comb begin
      rnd = acc_ff + AccW'(64'sd1 <<< 29);
      shifted = rnd[AccW-1:30];
      if (shifted > (AccW-30)'(64'sd2147483647))
         sat_val = 32'sh7FFFFFFF;
      else if (shifted < -(AccW-30)'(64'sd2147483648))
         sat_val = 32'sh80000000;
      else
         sat_val = shifted[ValueWidth-1:0];
   end

   assign rd_addr = AW'(32'(k_ff) * DIMS + 32'(d_ff));
   assign busy = (state_ff != ST_IDLE);

   // next partial remainder before the compare
   logic [TimeWidth:0] trial;
   assign trial = {part_ff, rem_ff[TimeWidth+16]};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         rsp_valid <= 1'b0;
         rvalid_ff <= 1'b0;
      end else begin
         rsp_valid <= (state_ff == ST_OUT);
         case (state_ff)
            ST_IDLE: begin
               if (accept && req_type == REQ_EVAL) begin
                  n_ff  <= (32'(degree_ff) > MAX_DEGREE) ? KW'(MAX_DEGREE)
                                                         : KW'(degree_ff);
                  ft_ff <= ft_eff;
                  if (req_eval_time > ft_eff) begin
                     clamped_ff <= 1'b1;
                     div_cnt_ff <= '0;
                  end else begin
                     clamped_ff <= 1'b0;
                     div_cnt_ff <= 5'd17;
                  end
                  // quotient fits 17 bits, so the top 16 dividend bits are below ft
                  part_ff  <= dividend[TimeWidth+16:17];
                  rem_ff   <= {dividend[16:0], 16'd0};
                  quo_ff   <= '0;
                  state_ff <= ST_DIV;
               end
            end
            ST_DIV: begin
               // restoring division, one quotient bit a cycle, msb first
               if (div_cnt_ff != '0) begin
                  if (trial >= {1'b0, ft_ff}) begin
                     part_ff <= TimeWidth'(trial - {1'b0, ft_ff});
                     quo_ff  <= {quo_ff[TimeWidth-1:0], 1'b1};
                  end else begin
                     part_ff <= trial[TimeWidth-1:0];
                     quo_ff  <= {quo_ff[TimeWidth-1:0], 1'b0};
                  end
                  rem_ff     <= {rem_ff[TimeWidth+15:0], 1'b0};
                  div_cnt_ff <= div_cnt_ff - 5'd1;
               end else begin
                  tau_ff    <= clamped_ff ? TauWidth'(17'h10000) : quo_ff;
                  w_ff[0]   <= WeightWidth'(1) << 30;
                  lvl_ff    <= KW'(1);
                  k_ff      <= '0;
                  wprev_ff  <= '0;
                  d_ff      <= '0;
                  acc_ff    <= '0;
                  rvalid_ff <= 1'b0;
                  state_ff  <= (n_ff == '0) ? ST_MAC : ST_LEVEL;
               end
            end
            ST_LEVEL: begin
               if (lvl_ff > n_ff) begin
                  state_ff <= ST_MAC;
                  k_ff <= '0;
                  d_ff <= '0;
                  acc_ff <= '0;
                  rvalid_ff <= 1'b0;
               end else begin
                  w_ff[k_ff[KW-2:0]] <= lvl_sum[WeightWidth+15:16];
                  wprev_ff <= wk_cur;
                  if (k_ff == lvl_ff) begin
                     k_ff   <= '0;
                     lvl_ff <= lvl_ff + KW'(1);
                  end else begin
                     k_ff <= k_ff + KW'(1);
                  end
               end
            end
            ST_MAC: begin
               // issue read for k_ff, accumulate the previous beat
               rvalid_ff <= (k_ff <= n_ff);
               rk_ff     <= k_ff;
               if (k_ff <= n_ff) k_ff <= k_ff + KW'(1);
               if (rvalid_ff) acc_ff <= acc_ff + AccW'(prod);
               if (!rvalid_ff && k_ff > n_ff) state_ff <= ST_OUT;
            end
            ST_OUT: begin
               rsp_out_dim <= DimWidth'(d_ff);
               rsp_value   <= sat_val;
               rsp_clamped <= clamped_ff;
               rsp_last    <= (32'(d_ff) == DIMS - 1);
               acc_ff <= '0;
               k_ff   <= '0;
               rvalid_ff <= 1'b0;
               if (32'(d_ff) == DIMS - 1) begin
                  state_ff <= ST_IDLE;
               end else begin
                  d_ff <= d_ff + DW'(1);
                  state_ff <= ST_MAC;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end
endmodule

[hw/rtl/bpe_checker.sv]
// Checker: port-level properties of the evaluator core, bound to the top level.
module bpe_checker
   import bpe_pkg::*;
(
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic req_type,
   input logic rsp_valid,
   input logic rsp_last
);
   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |=> !rsp_valid)
      else $error("result right after the last beat");
   a_load_no_rsp: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_type == REQ_LOAD |=> !rsp_valid)
      else $error("load gave a result");
   a_eval_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_type == REQ_EVAL |=> busy)
      else $error("evaluate did not raise busy");
   a_idle_quiet: assert property (@(posedge clock) disable iff (reset)
      !busy && !$past(busy) |-> !rsp_valid)
      else $error("result while idle");
endmodule

bind bernstein_polynomial_evaluator_core bpe_checker u_bpe_checker (
   .clock(clock), .reset(reset), .start(start), .busy(busy),
   .req_type(req_type), .rsp_valid(rsp_valid), .rsp_last(rsp_last)
);
